// ----- rtl/assert_macros.svh -----
// Assertion macros used by the register file top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication on clk, disabled in reset.
`define AST_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: name");
// Next-cycle implication on clk, disabled in reset.
`define AST_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: name");
`else
`define AST_IMPLY(name, ante, cons)
`define AST_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/dbr_pkg.sv -----
// Constants and command codes for the decimal bignum register file.
package dbr_pkg;
  localparam int DIGITS    = 64;
  localparam int VARIABLES = 10;

  localparam int IDX_W  = $clog2(DIGITS);
  localparam int LEN_W  = $clog2(DIGITS + 1);
  localparam int VSEL_W = $clog2(VARIABLES);
  localparam int ADDR_W = $clog2(VARIABLES * DIGITS);
  localparam int CMD_W  = 3;
  localparam int VAR_W  = 4;
  localparam int DIG_W  = 4;

  localparam logic [CMD_W-1:0] CMD_LIT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ASN_LIT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ASN_VAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_LIT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD_VAR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ECHO    = 3'd5;

  localparam logic [DIG_W-1:0] DIG_MAX = 4'd9;
  localparam logic [DIG_W:0]   RADIX   = 5'd10;

  typedef logic [DIG_W-1:0] digit_t;
endpackage

// ----- rtl/decimal_bignum_register_file_top.sv -----
// Decimal bignum register file: digit-serial assign, add and echo over a digit memory.
// Literal digit: taken in the accept cycle, busy stays low, next item the next cycle.
// Assign/add: busy while all DIGITS digits are walked, one digit per cycle through the digit memory.
// Echo of an n-digit variable: busy while its n digits are walked, most significant digit out first.
// Throughput is set by the single digit walk; the receiver cannot stall the echo stream.
// rst_n (sync, low) zeroes every variable at once through per-row valid bits; no clear pass.
`include "assert_macros.svh"

module decimal_bignum_register_file_top
  import dbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  logic [VAR_W-1:0] in_target_var,
  input  logic [VAR_W-1:0] in_source_var,
  input  logic [DIG_W-1:0] in_literal_digit,
  input  logic             in_literal_first,
  output logic             out_valid,
  output logic [DIG_W-1:0] out_digit,
  output logic             out_last
);

  // Digit storage: one row of DIGITS entries per variable, least significant first.
  // A row whose valid bit is clear reads as zero (the reset value).
  digit_t var_mem [VARIABLES*DIGITS];
  // Staged literal, kept in arrival order (most significant first).
  digit_t stg_mem [DIGITS];

  logic [VARIABLES-1:0] row_vld_r, row_vld_nxt;
  logic [LEN_W-1:0]     len_r [VARIABLES];
  logic [LEN_W-1:0]     stg_len_r, stg_len_nxt;

  // Command sequencer
  logic              run_r, run_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic [VSEL_W-1:0] tgt_r, tgt_nxt;
  logic [VSEL_W-1:0] src_r, src_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic              tv_r, tv_nxt;     // target row held data at command start
  logic              sv_r, sv_nxt;     // source row held data at command start

  // Digit stage: memory data registered, compute and write back
  logic              p1_vld_r, p1_vld_nxt;
  logic              p1_last_r, p1_last_nxt;
  logic [IDX_W-1:0]  p1_idx_r, p1_idx_nxt;
  logic              p1_srng_r, p1_srng_nxt;
  logic              carry_r, carry_nxt;
  logic [LEN_W-1:0]  hi_r, hi_nxt;     // trimmed length so far
  digit_t            rd_a_r, rd_b_r, stg_rd_r;

  logic              accept;
  logic              tgt_ok, src_ok;
  logic [VSEL_W-1:0] in_tgt, in_src;
  logic [IDX_W-1:0]  idx_a;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_w;
  logic [IDX_W-1:0]  stg_raddr, stg_waddr;
  logic              stg_we;
  digit_t            lit_dig;
  digit_t            dig_a, dig_b, dig_w;
  logic [DIG_W:0]    sum;
  logic              sum_ge;
  logic              is_echo, is_lit_src, is_add;
  logic              wr_en;
  logic [LEN_W-1:0]  trim;

  assign accept  = start && !busy;
  assign busy    = run_r || p1_vld_r;
  assign in_tgt  = VSEL_W'(in_target_var);
  assign in_src  = VSEL_W'(in_source_var);
  assign tgt_ok  = ({1'b0, in_target_var} < (VAR_W+1)'(VARIABLES));
  assign src_ok  = ({1'b0, in_source_var} < (VAR_W+1)'(VARIABLES));

  assign is_echo    = (op_r == CMD_ECHO);
  assign is_lit_src = (op_r == CMD_ASN_LIT) || (op_r == CMD_ADD_LIT);
  assign is_add     = (op_r == CMD_ADD_LIT) || (op_r == CMD_ADD_VAR);

  // Literal digit path
  assign lit_dig   = (in_literal_digit > DIG_MAX) ? DIG_MAX : in_literal_digit;
  assign stg_waddr = in_literal_first ? '0 : stg_len_r[IDX_W-1:0];
  assign stg_we    = accept && (in_command == CMD_LIT) &&
                     (in_literal_first || (stg_len_r < LEN_W'(DIGITS)));

  // Read addresses for the current walk position; echo walks down from the top digit
  assign idx_a     = is_echo ? (end_r - cnt_r) : cnt_r;
  assign addr_a    = ADDR_W'(tgt_r) * ADDR_W'(DIGITS) + ADDR_W'(idx_a);
  assign addr_b    = ADDR_W'(src_r) * ADDR_W'(DIGITS) + ADDR_W'(cnt_r);
  assign addr_w    = ADDR_W'(tgt_r) * ADDR_W'(DIGITS) + ADDR_W'(p1_idx_r);
  assign stg_raddr = IDX_W'(stg_len_r - LEN_W'(1) - LEN_W'(cnt_r));

  // Digit arithmetic
  always_comb begin
    dig_a = tv_r ? rd_a_r : '0;
    if (is_lit_src) begin
      dig_b = p1_srng_r ? stg_rd_r : '0;
    end else begin
      dig_b = sv_r ? rd_b_r : '0;
    end
    sum    = {1'b0, dig_a} + {1'b0, dig_b} + {{DIG_W{1'b0}}, carry_r};
    sum_ge = is_add && (sum >= RADIX);
    if (!is_add) begin
      dig_w = dig_b;
    end else if (sum_ge) begin
      dig_w = DIG_W'(sum - RADIX);
    end else begin
      dig_w = DIG_W'(sum);
    end
    trim  = (dig_w != '0) ? (LEN_W'(p1_idx_r) + LEN_W'(1)) : hi_r;
    wr_en = p1_vld_r && !is_echo;
  end

  // Command decode and digit walk
  always_comb begin
    run_nxt     = run_r;
    op_nxt      = op_r;
    tgt_nxt     = tgt_r;
    src_nxt     = src_r;
    cnt_nxt     = cnt_r;
    end_nxt     = end_r;
    tv_nxt      = tv_r;
    sv_nxt      = sv_r;
    row_vld_nxt = row_vld_r;
    stg_len_nxt = stg_len_r;
    carry_nxt   = carry_r;
    hi_nxt      = hi_r;
    p1_vld_nxt  = 1'b0;
    p1_last_nxt = 1'b0;
    p1_idx_nxt  = idx_a;
    p1_srng_nxt = (LEN_W'(cnt_r) < stg_len_r);

    if (accept) begin
      tgt_nxt   = in_tgt;
      src_nxt   = in_src;
      op_nxt    = in_command;
      cnt_nxt   = '0;
      tv_nxt    = row_vld_r[in_tgt];
      sv_nxt    = row_vld_r[in_src];
      carry_nxt = 1'b0;
      hi_nxt    = LEN_W'(1);
      end_nxt   = IDX_W'(DIGITS - 1);
      unique case (in_command) inside
        CMD_LIT: begin
          if (stg_we) begin
            stg_len_nxt = in_literal_first ? LEN_W'(1) : (stg_len_r + LEN_W'(1));
          end
        end
        CMD_ASN_LIT, CMD_ADD_LIT: begin
          if (tgt_ok) begin
            run_nxt = 1'b1;
            row_vld_nxt[in_tgt] = 1'b1;
          end
        end
        CMD_ASN_VAR, CMD_ADD_VAR: begin
          if (tgt_ok && src_ok) begin
            run_nxt = 1'b1;
            row_vld_nxt[in_tgt] = 1'b1;
          end
        end
        CMD_ECHO: begin
          if (tgt_ok) begin
            run_nxt = 1'b1;
            end_nxt = IDX_W'(len_r[in_tgt] - LEN_W'(1));
          end
        end
        default: begin
        end
      endcase
    end else if (run_r) begin
      p1_vld_nxt  = 1'b1;
      p1_last_nxt = (cnt_r == end_r);
      if (cnt_r == end_r) begin
        run_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
    end

    if (wr_en) begin
      carry_nxt = sum_ge;
      hi_nxt    = trim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      p1_vld_r  <= 1'b0;
      row_vld_r <= '0;
      stg_len_r <= '0;
      for (int v = 0; v < VARIABLES; v++) begin
        len_r[v] <= LEN_W'(1);
      end
    end else begin
      run_r     <= run_nxt;
      p1_vld_r  <= p1_vld_nxt;
      row_vld_r <= row_vld_nxt;
      stg_len_r <= stg_len_nxt;
      if (wr_en && p1_last_r) begin
        len_r[tgt_r] <= trim;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tgt_r     <= tgt_nxt;
    src_r     <= src_nxt;
    cnt_r     <= cnt_nxt;
    end_r     <= end_nxt;
    tv_r      <= tv_nxt;
    sv_r      <= sv_nxt;
    carry_r   <= carry_nxt;
    hi_r      <= hi_nxt;
    p1_last_r <= p1_last_nxt;
    p1_idx_r  <= p1_idx_nxt;
    p1_srng_r <= p1_srng_nxt;
  end

  // Digit and staging memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    rd_a_r   <= var_mem[addr_a];
    rd_b_r   <= var_mem[addr_b];
    stg_rd_r <= stg_mem[stg_raddr];
    if (wr_en) begin
      var_mem[addr_w] <= dig_w;
    end
    if (stg_we) begin
      stg_mem[stg_waddr] <= lit_dig;
    end
  end

  // Echo stream comes straight off the registered read data
  assign out_valid = p1_vld_r && is_echo;
  assign out_digit = tv_r ? rd_a_r : '0;
  assign out_last  = p1_last_r;

  `AST_IMPLY(a_out_in_cmd, out_valid, busy)
  `AST_NEXT(a_last_ends, out_valid && out_last, !out_valid)
  `AST_NEXT(a_add_runs, accept && (in_command == CMD_ADD_VAR) && tgt_ok && src_ok, busy)
  `AST_NEXT(a_lit_free, accept && (in_command == CMD_LIT), !busy)

endmodule

// ----- tb/decimal_bignum_register_file_top_tb.sv -----
// Testbench for the decimal bignum register file: directed and random command stream, digit echo checks.
module decimal_bignum_register_file_top_tb
  import dbr_pkg::*;
();

  // Command codes the block must ignore.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int ITEM_TARGET = 360;
  // Longest quiet stretch in a good run is a random driver gap plus a full assign/add walk.
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  // One input item, in port order.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAR_W-1:0] target_var;
    logic [VAR_W-1:0] source_var;
    logic [DIG_W-1:0] literal_digit;
    logic             literal_first;
  } cmd_item_t;

  // One echoed digit as the monitor expects to see it.
  typedef struct packed {
    digit_t digit;
    logic   last;
  } echo_digit_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CMD_W-1:0] in_command = '0;
  logic [VAR_W-1:0] in_target_var = '0;
  logic [VAR_W-1:0] in_source_var = '0;
  logic [DIG_W-1:0] in_literal_digit = '0;
  logic             in_literal_first = 1'b0;
  logic             out_valid;
  logic [DIG_W-1:0] out_digit;
  logic             out_last;

  decimal_bignum_register_file_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_target_var    (in_target_var),
    .in_source_var    (in_source_var),
    .in_literal_digit (in_literal_digit),
    .in_literal_first (in_literal_first),
    .out_valid        (out_valid),
    .out_digit        (out_digit),
    .out_last         (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file. Digits are held least significant first;
  // the staged literal is held in arrival order, most significant first.
  // ---------------------------------------------------------------------------
  digit_t var_digit [VARIABLES][DIGITS];
  int     var_len   [VARIABLES];
  digit_t lit_digit [DIGITS];
  int     lit_len;

  cmd_item_t   pending_q[$];        // items not yet handed to the driver
  echo_digit_t echoed_digits_q[$];  // digits the block still owes us

  int queued_count   = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;
  int gap_left       = 0;
  bit calm           = 1'b0;

  // Advance the shadow state by one accepted item; queue any echoed digits.
  function automatic void apply_command(input cmd_item_t it);
    digit_t operand [DIGITS];
    digit_t sum_d   [DIGITS];
    digit_t d;
    int     tv;
    int     sv;
    int     n;
    int     i;
    int     s;
    int     carry;
    tv = int'(it.target_var);
    sv = int'(it.source_var);
    if (it.command == CMD_LIT) begin
      d = (it.literal_digit > DIG_MAX) ? DIG_MAX : it.literal_digit;
      if (it.literal_first) lit_len = 0;
      // digits beyond capacity are dropped
      if (lit_len < DIGITS) begin
        lit_digit[lit_len] = d;
        lit_len++;
      end
      return;
    end
    if (it.command > CMD_ECHO || tv >= VARIABLES) return;
    if ((it.command == CMD_ASN_VAR || it.command == CMD_ADD_VAR) && sv >= VARIABLES) return;

    if (it.command == CMD_ECHO) begin
      n = var_len[tv];
      for (i = 0; i < n; i++)
        echoed_digits_q.push_back('{digit: var_digit[tv][n-1-i], last: (i == n - 1)});
      return;
    end

    // Operand: staged literal (empty reads as zero) or a snapshot of the source.
    for (i = 0; i < DIGITS; i++) begin
      if (it.command == CMD_ASN_LIT || it.command == CMD_ADD_LIT)
        operand[i] = (i < lit_len) ? lit_digit[lit_len-1-i] : digit_t'(0);
      else
        operand[i] = var_digit[sv][i];
    end

    // Ripple add over the full width; the carry out of the top digit is lost.
    carry = 0;
    for (i = 0; i < DIGITS; i++) begin
      if (it.command == CMD_ADD_LIT || it.command == CMD_ADD_VAR) begin
        s = var_digit[tv][i] + operand[i] + carry;
        carry = (s >= RADIX) ? 1 : 0;
        sum_d[i] = digit_t'(s - carry * RADIX);
      end else begin
        sum_d[i] = operand[i];
      end
    end

    var_digit[tv] = sum_d;
    // trim leading zeros, never below one digit
    var_len[tv] = 1;
    for (i = DIGITS - 1; i > 0; i--) begin
      if (sum_d[i] != 0) begin
        var_len[tv] = i + 1;
        break;
      end
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int tv, input int sv,
                           input int dg, input bit first);
    pending_q.push_back('{command: cmd, target_var: VAR_W'(tv), source_var: VAR_W'(sv),
                          literal_digit: DIG_W'(dg), literal_first: first});
    queued_count++;
  endtask

  // Fill the staged literal with nines past capacity, store it, echo it,
  // then add one so the carry runs off the top, the value wraps to zero and is echoed.
  task automatic push_capacity_wrap(input int tv);
    int i;
    for (i = 0; i < DIGITS + 3; i++)
      push_item(CMD_LIT, $urandom_range(0, 15), $urandom_range(0, 15), int'(DIG_MAX), i == 0);
    push_item(CMD_ASN_LIT, tv, $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
    push_item(CMD_ECHO, tv, $urandom_range(0, 15), $urandom_range(0, 15), 1'b1);
    push_item(CMD_LIT, $urandom_range(0, 15), $urandom_range(0, 15), 1, 1'b1);
    push_item(CMD_ADD_LIT, tv, $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
    push_item(CMD_ECHO, tv, $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
  endtask

  // Well-formed sequence: literal run, one assign/add, then echo the result and sometimes the source.
  task automatic push_operation();
    int run;
    int tv;
    int sv;
    int i;
    int dg;
    bit nines;
    logic [CMD_W-1:0] op;
    if ($urandom_range(0, 11) == 0) run = $urandom_range(DIGITS - 8, DIGITS + 4);
    else run = $urandom_range(1, 6);
    nines = ($urandom_range(0, 2) == 0);
    tv = $urandom_range(0, VARIABLES - 1);
    sv = $urandom_range(0, VARIABLES - 1);
    for (i = 0; i < run; i++) begin
      if (nines) dg = int'(DIG_MAX);
      else if ($urandom_range(0, 11) == 0) dg = $urandom_range(10, 15);  // clamps to nine
      else dg = $urandom_range(0, 9);
      // now and then the run extends the previous literal instead of restarting
      push_item(CMD_LIT, $urandom_range(0, 15), $urandom_range(0, 15), dg,
                i == 0 && $urandom_range(0, 5) != 0);
    end
    op = CMD_W'($urandom_range(CMD_ASN_LIT, CMD_ADD_VAR));
    push_item(op, tv, sv, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    push_item(CMD_ECHO, tv, $urandom_range(0, 15), $urandom_range(0, 15),
              1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      push_item(CMD_ECHO, sv, $urandom_range(0, 15), $urandom_range(0, 15), 1'b0);
  endtask

  // Noise: any field value, including spare commands and out-of-range indexes.
  task automatic push_noise();
    int k;
    int i;
    k = $urandom_range(1, 4);
    for (i = 0; i < k; i++)
      push_item(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 15), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int v;
    int i;
    int pick;
    for (v = 0; v < VARIABLES; v++) begin
      for (i = 0; i < DIGITS; i++) var_digit[v][i] = '0;
      var_len[v] = 1;
    end
    for (i = 0; i < DIGITS; i++) lit_digit[i] = '0;
    lit_len = 0;

    // Directed part.
    push_item(CMD_ASN_LIT, 0, 0, 0, 1'b0);      // nothing staged yet: stores zero
    push_item(CMD_ECHO, 0, 0, 0, 1'b0);
    push_item(CMD_ECHO, 9, 0, 0, 1'b0);         // untouched variable reads zero
    push_item(CMD_LIT, 0, 0, 15, 1'b1);         // over-range digit clamps to nine
    push_item(CMD_LIT, 0, 0, 0, 1'b0);
    push_item(CMD_LIT, 0, 0, 7, 1'b0);
    push_item(CMD_ASN_LIT, 1, 0, 0, 1'b0);      // var1 = 907
    push_item(CMD_ECHO, 1, 0, 0, 1'b0);
    push_item(CMD_LIT, 0, 0, 0, 1'b1);          // leading zeros: 009
    push_item(CMD_LIT, 0, 0, 0, 1'b0);
    push_item(CMD_LIT, 0, 0, 9, 1'b0);
    push_item(CMD_ADD_LIT, 1, 0, 0, 1'b0);      // 916, carry across a digit
    push_item(CMD_ADD_VAR, 1, 1, 0, 1'b0);      // source equals target: doubles
    push_item(CMD_ASN_VAR, 9, 1, 0, 1'b0);
    push_item(CMD_ECHO, 9, 0, 0, 1'b0);
    push_item(CMD_ASN_LIT, 12, 0, 0, 1'b0);     // target out of range
    push_item(CMD_ECHO, 10, 0, 0, 1'b0);
    push_item(CMD_ECHO, 15, 15, 15, 1'b1);
    push_item(CMD_ASN_VAR, 2, 10, 0, 1'b0);     // source out of range
    push_item(CMD_ADD_VAR, 2, 15, 0, 1'b0);
    push_item(CMD_SPARE_6, 2, 1, 9, 1'b1);
    push_item(CMD_SPARE_7, 1, 2, 9, 1'b1);
    push_item(CMD_LIT, 0, 0, 12, 1'b1);
    push_item(CMD_ADD_LIT, 2, 0, 0, 1'b0);
    push_item(CMD_ECHO, 2, 0, 0, 1'b0);

    // Random part, opening with one full-capacity wrap.
    push_capacity_wrap($urandom_range(0, VARIABLES - 1));
    while (queued_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) push_capacity_wrap($urandom_range(0, VARIABLES - 1));
      else if (pick < 32) push_operation();
      else push_noise();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != queued_count) @(posedge clk);
    while (echoed_digits_q.size() != 0) @(posedge clk);
    // catch stray digits from the last walk
    repeat (DIGITS + 8) @(posedge clk);

    if (mismatch_count == 0 && echoed_digits_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: an item goes when start && !busy at an edge. The next item is
  // presented after a random gap; calm stretches run back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_item_t nxt;
    logic      go;
    int        gap;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      go  = start;
      gap = gap_left;
      if (start && !busy) begin
        apply_command({in_command, in_target_var, in_source_var,
                       in_literal_digit, in_literal_first});
        accepted_count++;
        go = 1'b0;
        if ($urandom_range(0, 24) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 11);
      end
      if (!go) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_command       <= nxt.command;
          in_target_var    <= nxt.target_var;
          in_source_var    <= nxt.source_var;
          in_literal_digit <= nxt.literal_digit;
          in_literal_first <= nxt.literal_first;
          go = 1'b1;
        end
      end
      // single update of start per edge keeps back-to-back items clean
      start    <= go;
      gap_left <= gap;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed digit is matched against the oldest expected one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    echo_digit_t want;
    if (rst_n && out_valid) begin
      if (echoed_digits_q.size() == 0) begin
        flag_mismatch($sformatf("digit %0d last %0b with nothing pending",
                                out_digit, out_last));
      end else begin
        want = echoed_digits_q.pop_front();
        if (out_digit !== want.digit)
          flag_mismatch($sformatf("out_digit expected %0d, got %0d", want.digit, out_digit));
        if (out_last !== want.last)
          flag_mismatch($sformatf("out_last expected %0b, got %0b", want.last, out_last));
      end
    end
  end

  // Watchdog: too long with neither an item taken nor a digit out means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

// ----- decimal_bignum_register_file_top.f -----
+incdir+rtl
rtl/dbr_pkg.sv
rtl/decimal_bignum_register_file_top.sv
tb/decimal_bignum_register_file_top_tb.sv
